### src/fasta_record_index_scanner_core_assert.svh
// Assertion macros for the record index scanner.
`ifndef FASTA_RECORD_INDEX_SCANNER_CORE_ASSERT_SVH
`define FASTA_RECORD_INDEX_SCANNER_CORE_ASSERT_SVH

// same-cycle implication
`define FRISC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define FRISC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/frisc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package frisc_pkg;

	localparam int OUT_W   = 32;
	localparam int QDEPTH  = 4;
	localparam int QPTR_W  = $clog2(QDEPTH);
	localparam int QCNT_W  = $clog2(QDEPTH + 1);

	localparam logic [7:0] CHR_GT   = 8'd62;
	localparam logic [7:0] CHR_CR   = 8'd13;
	localparam logic [7:0] CHR_LF   = 8'd10;
	localparam logic [7:0] CHR_G    = 8'd71;
	localparam logic [7:0] CHR_C    = 8'd67;
	localparam logic [7:0] CHR_N    = 8'd78;
	localparam logic [7:0] CHR_G_LC = 8'd103;
	localparam logic [7:0] CHR_C_LC = 8'd99;
	localparam logic [7:0] CHR_N_LC = 8'd110;

	localparam logic [1:0] MISM_MAX = 2'd2;

	typedef enum logic [2:0] {
		CLS_OTHER,
		CLS_GC,
		CLS_N,
		CLS_CR,
		CLS_LF,
		CLS_GT,
		CLS_EOI
	} cls_t;

	typedef struct packed {
		logic [OUT_W-1:0] body_start;
		logic [OUT_W-1:0] body_bytes;
		logic [OUT_W-1:0] residue_count;
		logic [OUT_W-1:0] first_line_length;
		logic             crlf_ends;
		logic             uniform_lines;
		logic [OUT_W-1:0] gc_count;
		logic [OUT_W-1:0] n_count;
	} rec_t;

endpackage
`default_nettype wire

### src/fasta_record_index_scanner_core.sv
// channel | handshake           | words
// --------+---------------------+--------------------------------------------
// in      | in_valid, in_ready  | data_byte, end_of_input
// out     | out_valid, out_ready| body_start, body_bytes, residue_count,
//         |                     | first_line_length, crlf_ends,
//         |                     | uniform_lines, gc_count, n_count
//
// One byte per cycle sustained while in_ready is high; a result passes through
// the queue, then the output register, after the byte that closes its record.
// A four-entry queue sits between the byte classifier and the counter unit.
// Only a record-closing word stalls the counter unit, and only while the
// previous result waits; in_ready stays high until the queue holds four words.
// arst_n clears all counters and empties the queue; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module fasta_record_index_scanner_core #(
	parameter int COUNT_WIDTH = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        end_of_input,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [31:0]      body_start,
	output logic [31:0]      body_bytes,
	output logic [31:0]      residue_count,
	output logic [31:0]      first_line_length,
	output logic             crlf_ends,
	output logic             uniform_lines,
	output logic [31:0]      gc_count,
	output logic [31:0]      n_count
);
	import frisc_pkg::*;

	cls_t front_cls;
	cls_t back_cls;
	logic q_valid;
	logic q_pop;
	rec_t rec;

	frisc_front u_front (
		.data_byte    (data_byte),
		.end_of_input (end_of_input),
		.cls          (front_cls)
	);

	frisc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (in_valid),
		.push_ready (in_ready),
		.push_cls   (front_cls),
		.pop_valid  (q_valid),
		.pop        (q_pop),
		.pop_cls    (back_cls)
	);

	frisc_back #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (q_valid),
		.item_cls   (back_cls),
		.item_pop   (q_pop),
		.rec_valid  (out_valid),
		.rec_ready  (out_ready),
		.rec        (rec)
	);

	assign body_start        = rec.body_start;
	assign body_bytes        = rec.body_bytes;
	assign residue_count     = rec.residue_count;
	assign first_line_length = rec.first_line_length;
	assign crlf_ends         = rec.crlf_ends;
	assign uniform_lines     = rec.uniform_lines;
	assign gc_count          = rec.gc_count;
	assign n_count           = rec.n_count;

endmodule
`default_nettype wire

### src/frisc_front.sv
`timescale 1ns / 1ps
`default_nettype none
module frisc_front (
	input  wire logic [7:0]      data_byte,
	input  wire logic            end_of_input,
	output frisc_pkg::cls_t      cls
);
	import frisc_pkg::*;

	always_comb begin
		if (end_of_input) begin
			cls = CLS_EOI;
		end else begin
			unique case (data_byte) inside
				CHR_GT: cls = CLS_GT;
				CHR_CR: cls = CLS_CR;
				CHR_LF: cls = CLS_LF;
				CHR_G, CHR_G_LC, CHR_C, CHR_C_LC: cls = CLS_GC;
				CHR_N, CHR_N_LC: cls = CLS_N;
				default: cls = CLS_OTHER;
			endcase
		end
	end

endmodule
`default_nettype wire

### src/frisc_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module frisc_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push_valid,
	output logic                 push_ready,
	input  wire frisc_pkg::cls_t push_cls,
	output logic                 pop_valid,
	input  wire logic            pop,
	output frisc_pkg::cls_t      pop_cls
);
	import frisc_pkg::*;

	cls_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = (cnt_q != QCNT_W'(QDEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_cls    = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

### src/frisc_back.sv
`timescale 1ns / 1ps
`default_nettype none
module frisc_back #(
	parameter int COUNT_WIDTH = 32
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            item_valid,
	input  wire frisc_pkg::cls_t item_cls,
	output logic                 item_pop,
	output logic                 rec_valid,
	input  wire logic            rec_ready,
	output frisc_pkg::rec_t      rec
);
	import frisc_pkg::*;

	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

	function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
		return (v == CNT_MAX) ? v : v + 1'b1;
	endfunction

	function automatic logic [OUT_W-1:0] low_word(input logic [COUNT_WIDTH-1:0] v);
		logic [63:0] ext;
		ext = 64'(v);
		return ext[OUT_W-1:0];
	endfunction

	logic                   in_header_q;
	logic                   open_q;
	logic [COUNT_WIDTH-1:0] offset_q;
	logic [COUNT_WIDTH-1:0] start_q;
	logic [COUNT_WIDTH-1:0] res_q;
	logic [COUNT_WIDTH-1:0] gc_q;
	logic [COUNT_WIDTH-1:0] n_q;
	logic [COUNT_WIDTH-1:0] ref_q;
	logic [COUNT_WIDTH-1:0] cur_q;
	logic                   cr_q;
	logic [1:0]             mism_q;

	logic                   emit;
	logic                   stall;
	logic [COUNT_WIDTH-1:0] off_inc;
	logic [COUNT_WIDTH-1:0] cur_inc;
	rec_t                   rec_d;

	assign off_inc  = sat_inc(offset_q);
	assign cur_inc  = sat_inc(cur_q);
	assign emit     = open_q && ((item_cls == CLS_EOI) || (!in_header_q && (item_cls == CLS_GT)));
	assign stall    = emit && rec_valid && !rec_ready;
	assign item_pop = item_valid && !stall;

	always_comb begin
		rec_d.body_start        = low_word(in_header_q ? offset_q : start_q);
		rec_d.body_bytes        = in_header_q ? '0 : low_word(offset_q - start_q);
		rec_d.residue_count     = low_word(res_q);
		rec_d.first_line_length = low_word(ref_q);
		rec_d.crlf_ends         = cr_q;
		rec_d.uniform_lines     = (mism_q != MISM_MAX);
		rec_d.gc_count          = low_word(gc_q);
		rec_d.n_count           = low_word(n_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_header_q <= 1'b0;
			open_q      <= 1'b0;
			offset_q    <= '0;
			start_q     <= '0;
			res_q       <= '0;
			gc_q        <= '0;
			n_q         <= '0;
			ref_q       <= '0;
			cur_q       <= '0;
			cr_q        <= 1'b0;
			mism_q      <= '0;
		end else if (item_pop) begin
			if (item_cls == CLS_EOI) begin
				in_header_q <= 1'b0;
				open_q      <= 1'b0;
				offset_q    <= '0;
				start_q     <= '0;
				res_q       <= '0;
				gc_q        <= '0;
				n_q         <= '0;
				ref_q       <= '0;
				cur_q       <= '0;
				cr_q        <= 1'b0;
				mism_q      <= '0;
			end else if (in_header_q) begin
				offset_q <= off_inc;
				if (item_cls == CLS_LF) begin
					in_header_q <= 1'b0;
					start_q     <= off_inc;
				end
			end else if (item_cls == CLS_GT) begin
				offset_q    <= off_inc;
				open_q      <= 1'b1;
				in_header_q <= 1'b1;
				res_q       <= '0;
				gc_q        <= '0;
				n_q         <= '0;
				ref_q       <= '0;
				cur_q       <= '0;
				cr_q        <= 1'b0;
				mism_q      <= '0;
			end else begin
				offset_q <= off_inc;
				if (open_q) begin
					unique case (item_cls)
						CLS_CR: begin
							cur_q <= cur_inc;
							cr_q  <= 1'b1;
						end
						CLS_LF: begin
							cur_q <= '0;
							if (ref_q != '0) begin
								if (ref_q != cur_inc && mism_q != MISM_MAX) begin
									mism_q <= mism_q + 1'b1;
								end
							end else begin
								ref_q <= cur_inc;
							end
						end
						CLS_GC: begin
							res_q <= sat_inc(res_q);
							cur_q <= cur_inc;
							gc_q  <= sat_inc(gc_q);
						end
						CLS_N: begin
							res_q <= sat_inc(res_q);
							cur_q <= cur_inc;
							n_q   <= sat_inc(n_q);
						end
						default: begin
							res_q <= sat_inc(res_q);
							cur_q <= cur_inc;
						end
					endcase
				end
			end
		end
	end

	// hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_valid <= 1'b0;
		end else if (item_pop && emit) begin
			rec_valid <= 1'b1;
		end else if (rec_ready) begin
			rec_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_pop && emit) begin
			rec <= rec_d;
		end
	end

endmodule
`default_nettype wire

### src/frisc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "fasta_record_index_scanner_core_assert.svh"
module frisc_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [31:0] body_start,
	input wire logic [31:0] body_bytes,
	input wire logic [31:0] residue_count,
	input wire logic [31:0] first_line_length,
	input wire logic        uniform_lines,
	input wire logic [31:0] gc_count,
	input wire logic [31:0] n_count
);

	`FRISC_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
	`FRISC_ASSERT_NXT(a_out_stable, out_valid && !out_ready, $stable(body_start) && $stable(body_bytes), "result changed while stalled")
	`FRISC_ASSERT_IMP(a_empty_body, out_valid && body_bytes == 32'd0, residue_count == 32'd0 && gc_count == 32'd0 && n_count == 32'd0 && first_line_length == 32'd0, "counts without body bytes")
	`FRISC_ASSERT_IMP(a_no_line_uniform, out_valid && first_line_length == 32'd0, uniform_lines, "mismatch without a reference line")

endmodule

bind fasta_record_index_scanner_core frisc_checker u_frisc_checker (.*);
`default_nettype wire
